// ===== rtl/spmd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types and constants for the signal pending/mask dispatch unit.
// ----------------------------------------------------------------------------
package spmd_pkg;

    localparam int NUM_SIGNALS = 64;
    localparam int IDX_W       = $clog2(NUM_SIGNALS);

    localparam logic [6:0] SIG_UNMASKABLE_A = 7'd9;
    localparam logic [6:0] SIG_UNMASKABLE_B = 7'd19;

    localparam logic [2:0] MODE_RAISE   = 3'd0;
    localparam logic [2:0] MODE_MASK    = 3'd1;
    localparam logic [2:0] MODE_SETDISP = 3'd2;
    localparam logic [2:0] MODE_DELIVER = 3'd3;
    localparam logic [2:0] MODE_QUERY   = 3'd4;

    localparam logic [1:0] HOW_BLOCK   = 2'd0;
    localparam logic [1:0] HOW_UNBLOCK = 2'd1;
    localparam logic [1:0] HOW_SET     = 2'd2;

    localparam logic [1:0] DISP_DEFAULT = 2'd0;
    localparam logic [1:0] DISP_IGNORE  = 2'd1;
    localparam logic [1:0] DISP_HANDLER = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef logic [NUM_SIGNALS-1:0] t_sigvec;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  signal_number;
        logic [1:0]  mask_how;
        logic [63:0] signal_set;
        logic [1:0]  disposition;
        logic        oneshot_flag;
        logic        restart_flag;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [6:0]  delivered_signal;
        logic [63:0] bitmap_out;
        logic [1:0]  old_disposition;
        logic        has_pending;
        logic        restart_wanted;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/spmd_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_in_stage
// Input register: captures one beat and holds it until the core advances.
// ----------------------------------------------------------------------------
module spmd_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire spmd_pkg::t_in_item i_item,
    input  wire logic              i_adv,
    output logic                   o_vld,
    output spmd_pkg::t_in_item     o_item
);
    import spmd_pkg::*;

    logic     r_vld;
    t_in_item r_item;
    logic     accept;

    assign o_ready = !r_vld || i_adv;
    assign accept  = i_valid && o_ready;
    assign o_vld   = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/spmd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_core
// Pending, mask and disposition state with the single-pass result logic.
// ----------------------------------------------------------------------------
module spmd_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire spmd_pkg::t_in_item i_item,
    output spmd_pkg::t_out_item     o_res
);
    import spmd_pkg::*;

    t_sigvec r_pend, r_blocked, r_disp_lo, r_disp_hi, r_oneshot, r_restart;
    t_sigvec n_pend, n_blocked, n_disp_lo, n_disp_hi, n_oneshot, n_restart;

    t_sigvec    ready_vec, handler_vec, hit_vec, low_bit, clear_vec, set_vec, num_bit;
    t_sigvec    unmask_vec;
    logic [IDX_W-1:0] idx, hit_idx;
    logic       num_ok;
    t_out_item  res;

    assign handler_vec = r_disp_hi & ~r_disp_lo;
    assign ready_vec   = r_pend & ~r_blocked;
    assign hit_vec     = ready_vec & handler_vec;
    assign low_bit     = hit_vec & (~hit_vec + t_sigvec'(1));
    assign clear_vec   = (hit_vec == '0) ? ready_vec
                                         : ready_vec & (low_bit | (low_bit - t_sigvec'(1)));
    assign num_ok      = (i_item.signal_number >= 7'd1)
                      && (i_item.signal_number <= 7'(NUM_SIGNALS));
    assign idx         = IDX_W'(i_item.signal_number - 7'd1);
    assign num_bit     = t_sigvec'(1) << idx;
    assign unmask_vec  = (t_sigvec'(1) << IDX_W'(SIG_UNMASKABLE_A - 7'd1))
                       | (t_sigvec'(1) << IDX_W'(SIG_UNMASKABLE_B - 7'd1));
    assign set_vec     = i_item.signal_set[NUM_SIGNALS-1:0] & ~unmask_vec;

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < NUM_SIGNALS; i++) begin
            if (low_bit[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_pend    = r_pend;
        n_blocked = r_blocked;
        n_disp_lo = r_disp_lo;
        n_disp_hi = r_disp_hi;
        n_oneshot = r_oneshot;
        n_restart = r_restart;
        res       = '0;
        unique case (i_item.mode)
            MODE_RAISE: begin
                if (num_ok) begin
                    n_pend = r_pend | num_bit;
                end else begin
                    res.status = STATUS_INVALID;
                end
            end
            MODE_MASK: begin
                res.bitmap_out = 64'(r_blocked);
                unique case (i_item.mask_how)
                    HOW_BLOCK:   n_blocked = r_blocked | set_vec;
                    HOW_UNBLOCK: n_blocked = r_blocked & ~set_vec;
                    HOW_SET:     n_blocked = set_vec;
                    default:     res.status = STATUS_INVALID;
                endcase
            end
            MODE_SETDISP: begin
                if (!num_ok || i_item.signal_number == SIG_UNMASKABLE_A
                        || i_item.signal_number == SIG_UNMASKABLE_B
                        || i_item.disposition > DISP_HANDLER) begin
                    res.status = STATUS_INVALID;
                end else begin
                    res.old_disposition = {r_disp_hi[idx], r_disp_lo[idx]};
                    n_disp_lo[idx] = i_item.disposition[0];
                    n_disp_hi[idx] = i_item.disposition[1];
                    n_oneshot[idx] = i_item.oneshot_flag;
                    n_restart[idx] = i_item.restart_flag;
                end
            end
            MODE_DELIVER: begin
                n_pend = r_pend & ~clear_vec;
                if (hit_vec != '0) begin
                    res.delivered_signal = 7'(hit_idx) + 7'd1;
                    n_disp_lo = r_disp_lo & ~(low_bit & r_oneshot);
                    n_disp_hi = r_disp_hi & ~(low_bit & r_oneshot);
                end
            end
            MODE_QUERY: begin
                res.bitmap_out     = 64'(r_pend);
                res.has_pending    = (ready_vec != '0);
                res.restart_wanted = ((hit_vec & ~r_restart) == '0);
            end
            default: begin
                res.status = STATUS_INVALID;
            end
        endcase
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_blocked <= '0;
            r_disp_lo <= '0;
            r_disp_hi <= '0;
            r_oneshot <= '0;
            r_restart <= '0;
        end else if (i_adv) begin
            r_pend    <= n_pend;
            r_blocked <= n_blocked;
            r_disp_lo <= n_disp_lo;
            r_disp_hi <= n_disp_hi;
            r_oneshot <= n_oneshot;
            r_restart <= n_restart;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/spmd_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module spmd_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire spmd_pkg::t_out_item i_res,
    output logic                     o_free,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output spmd_pkg::t_out_item      o_data
);
    import spmd_pkg::*;

    logic      r_vld;
    t_out_item r_res;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/signal_pending_mask_dispatch.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signal_pending_mask_dispatch
// Throughput: one beat per cycle while i_out_ready stays high; each item
// passes the input register, one pass of combinational logic over the state
// vectors, then the result register; a busy result register stalls the input.
// Reset: synchronous; clears pending bits, blocked mask and all dispositions.
// ----------------------------------------------------------------------------
module signal_pending_mask_dispatch (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire spmd_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output spmd_pkg::t_out_item      o_out_data
);
    import spmd_pkg::*;

    logic      in_vld, out_free, adv;
    t_in_item  item;
    t_out_item res;

    assign adv = in_vld && out_free;

    spmd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_adv   (adv),
        .o_vld   (in_vld),
        .o_item  (item)
    );

    spmd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (item),
        .o_res   (res)
    );

    spmd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== bench/signal_pending_mask_dispatch_test.sv =====
// ----------------------------------------------------------------------------
// signal_pending_mask_dispatch_test
// Self-checking bench for the signal pending/mask dispatch unit. A clocked
// driver feeds input beats from a queue and predicts each result as its beat
// is accepted; a clocked monitor compares every result beat field by field
// with the oldest prediction. A directed opening covers the invalid numbers,
// unmaskable signals, bad codes, oneshot revert and empty deliver; random
// batches follow, each under one of four patterns of sender and receiver
// idling, with a full drain between batches.
// ----------------------------------------------------------------------------
module signal_pending_mask_dispatch_test;
    import spmd_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_B = 3'd6;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;
    localparam logic [1:0] HOW_BAD      = 2'd3;
    localparam logic [1:0] DISP_BAD     = 2'd3;
    localparam logic [6:0] SIG_NONE     = 7'd0;
    localparam logic [6:0] SIG_FIRST    = 7'd1;
    localparam logic [6:0] SIG_LAST     = 7'd64;
    localparam logic [6:0] SIG_MAX_CODE = 7'd127;
    localparam int         NUM_BATCHES  = 8;
    localparam int         BATCH_ITEMS  = 106;
    localparam int         MAX_REPORTS  = 50;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    t_in_item   request_q[$];
    t_out_item  result_q[$];
    t_out_item  expected_beat;
    t_sigvec    pend_bits;
    t_sigvec    blk_mask;
    logic [3:0] disp_tab [NUM_SIGNALS];
    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         mismatch_count;
    int         beat_count;

    signal_pending_mask_dispatch i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item predict_dispatch(input t_in_item it);
        t_out_item r;
        t_sigvec   clean;
        t_sigvec   ready_bits;
        int        idx;
        bit        found;
        r = '0;
        idx = int'(it.signal_number) - 1;
        case (it.mode)
            MODE_RAISE: begin
                if (it.signal_number >= SIG_FIRST && it.signal_number <= SIG_LAST)
                    pend_bits[idx] = 1'b1;
                else
                    r.status = STATUS_INVALID;
            end
            MODE_MASK: begin
                r.bitmap_out = blk_mask;
                clean = it.signal_set;
                clean[SIG_UNMASKABLE_A - 1] = 1'b0;
                clean[SIG_UNMASKABLE_B - 1] = 1'b0;
                case (it.mask_how)
                    HOW_BLOCK:   blk_mask = blk_mask | clean;
                    HOW_UNBLOCK: blk_mask = blk_mask & ~clean;
                    HOW_SET:     blk_mask = clean;
                    default:     r.status = STATUS_INVALID;
                endcase
            end
            MODE_SETDISP: begin
                if (it.signal_number < SIG_FIRST || it.signal_number > SIG_LAST
                        || it.signal_number == SIG_UNMASKABLE_A
                        || it.signal_number == SIG_UNMASKABLE_B
                        || it.disposition == DISP_BAD) begin
                    r.status = STATUS_INVALID;
                end else begin
                    r.old_disposition = disp_tab[idx][1:0];
                    disp_tab[idx] = {it.restart_flag, it.oneshot_flag, it.disposition};
                end
            end
            MODE_DELIVER: begin
                ready_bits = pend_bits & ~blk_mask;
                found = 1'b0;
                for (int s = 0; s < NUM_SIGNALS; s++) begin
                    if (!found && ready_bits[s]) begin
                        pend_bits[s] = 1'b0;
                        if (disp_tab[s][1:0] == DISP_HANDLER) begin
                            found = 1'b1;
                            r.delivered_signal = 7'(s + 1);
                            if (disp_tab[s][2])
                                disp_tab[s][1:0] = DISP_DEFAULT;
                        end
                    end
                end
            end
            MODE_QUERY: begin
                r.bitmap_out = pend_bits;
                ready_bits = pend_bits & ~blk_mask;
                r.has_pending = |ready_bits;
                r.restart_wanted = 1'b1;
                for (int s = 0; s < NUM_SIGNALS; s++) begin
                    if (ready_bits[s] && disp_tab[s][1:0] == DISP_HANDLER && !disp_tab[s][3])
                        r.restart_wanted = 1'b0;
                end
            end
            default: r.status = STATUS_INVALID;
        endcase
        return r;
    endfunction

    function automatic t_in_item make_request(input logic [2:0] mode, input logic [6:0] num,
                                              input logic [1:0] how, input logic [63:0] set,
                                              input logic [1:0] disp, input logic oneshot,
                                              input logic restart);
        t_in_item it;
        it.mode          = mode;
        it.signal_number = num;
        it.mask_how      = how;
        it.signal_set    = set;
        it.disposition   = disp;
        it.oneshot_flag  = oneshot;
        it.restart_flag  = restart;
        return it;
    endfunction

    function automatic logic [6:0] pick_signal();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 7'($urandom_range(SIG_LAST, SIG_FIRST));
        else if (roll < 80)
            return roll[0] ? SIG_UNMASKABLE_A : SIG_UNMASKABLE_B;
        else
            return 7'($urandom_range(SIG_MAX_CODE));
    endfunction

    function automatic logic [63:0] pick_set();
        case ($urandom_range(5))
            0:       return '1;
            1:       return '0;
            2, 3:    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_item random_request();
        t_in_item it;
        int       roll;
        it = make_request(3'($urandom_range(MODE_SPARE_C)), 7'($urandom_range(SIG_MAX_CODE)),
                          2'($urandom_range(HOW_BAD)), {$urandom, $urandom},
                          2'($urandom_range(DISP_BAD)), 1'($urandom), 1'($urandom));
        roll = $urandom_range(99);
        if (roll < 35) begin
            it.mode = MODE_RAISE;
            it.signal_number = pick_signal();
        end else if (roll < 47) begin
            it.mode = MODE_MASK;
            it.signal_set = pick_set();
            it.mask_how = ($urandom_range(15) == 0) ? HOW_BAD : 2'($urandom_range(HOW_SET));
        end else if (roll < 65) begin
            it.mode = MODE_SETDISP;
            it.signal_number = pick_signal();
            case ($urandom_range(9))
                0, 1, 2, 3, 4: it.disposition = DISP_HANDLER;
                5, 6:          it.disposition = DISP_IGNORE;
                7, 8:          it.disposition = DISP_DEFAULT;
                default:       it.disposition = DISP_BAD;
            endcase
        end else if (roll < 82) begin
            it.mode = MODE_DELIVER;
        end else if (roll < 95) begin
            it.mode = MODE_QUERY;
        end else begin
            it.mode = 3'(MODE_SPARE_A + $urandom_range(2));
        end
        return it;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("beat %0d: %s is %0h, predicted %0h", beat_count, field, got, want);
        mismatch_count++;
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || i_in_valid || result_q.size() != 0)
            @(posedge i_clk);
    endtask

    // driver: predict on acceptance, then present the next beat or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                result_q.push_back(predict_dispatch(i_in_data));
            if (!i_in_valid || o_in_ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= request_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected beat", o_out_data.bitmap_out, '0);
                end else begin
                    expected_beat = result_q.pop_front();
                    if (o_out_data.status !== expected_beat.status)
                        report_mismatch("status", 64'(o_out_data.status),
                                        64'(expected_beat.status));
                    if (o_out_data.delivered_signal !== expected_beat.delivered_signal)
                        report_mismatch("delivered_signal", 64'(o_out_data.delivered_signal),
                                        64'(expected_beat.delivered_signal));
                    if (o_out_data.bitmap_out !== expected_beat.bitmap_out)
                        report_mismatch("bitmap_out", o_out_data.bitmap_out,
                                        expected_beat.bitmap_out);
                    if (o_out_data.old_disposition !== expected_beat.old_disposition)
                        report_mismatch("old_disposition", 64'(o_out_data.old_disposition),
                                        64'(expected_beat.old_disposition));
                    if (o_out_data.has_pending !== expected_beat.has_pending)
                        report_mismatch("has_pending", 64'(o_out_data.has_pending),
                                        64'(expected_beat.has_pending));
                    if (o_out_data.restart_wanted !== expected_beat.restart_wanted)
                        report_mismatch("restart_wanted", 64'(o_out_data.restart_wanted),
                                        64'(expected_beat.restart_wanted));
                end
                beat_count++;
            end
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_in_data          = '0;
        i_out_ready        = 1'b0;
        pend_bits          = '0;
        blk_mask           = '0;
        mismatch_count     = 0;
        beat_count         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        foreach (disp_tab[k])
            disp_tab[k] = '0;

        request_q.push_back(make_request(MODE_QUERY, SIG_NONE, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_RAISE, SIG_NONE, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_RAISE, SIG_MAX_CODE, HOW_BAD, '1,
                                         DISP_BAD, 1'b1, 1'b1));
        request_q.push_back(make_request(MODE_RAISE, SIG_LAST + 7'd1, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_SETDISP, SIG_NONE, HOW_BLOCK, '0,
                                         DISP_HANDLER, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_SETDISP, SIG_UNMASKABLE_A, HOW_BLOCK, '0,
                                         DISP_HANDLER, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_SETDISP, SIG_UNMASKABLE_B, HOW_BLOCK, '0,
                                         DISP_IGNORE, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_SETDISP, 7'd5, HOW_BLOCK, '0,
                                         DISP_BAD, 1'b1, 1'b1));
        request_q.push_back(make_request(MODE_SETDISP, SIG_FIRST, HOW_BLOCK, '0,
                                         DISP_HANDLER, 1'b1, 1'b1));
        request_q.push_back(make_request(MODE_SETDISP, SIG_LAST, HOW_BLOCK, '0,
                                         DISP_HANDLER, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_SETDISP, 7'd2, HOW_BLOCK, '0,
                                         DISP_IGNORE, 1'b1, 1'b1));
        request_q.push_back(make_request(MODE_RAISE, SIG_FIRST, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_RAISE, SIG_LAST, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_RAISE, 7'd2, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_RAISE, 7'd3, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_MASK, SIG_NONE, HOW_BLOCK, '1,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_MASK, SIG_NONE, HOW_BAD, 64'h5555_5555_5555_5555,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_QUERY, SIG_NONE, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_MASK, SIG_NONE, HOW_UNBLOCK, '1,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_QUERY, SIG_NONE, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_DELIVER, SIG_NONE, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_DELIVER, SIG_NONE, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_DELIVER, SIG_NONE, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_MASK, SIG_NONE, HOW_SET, 64'hAAAA_AAAA_AAAA_AAAA,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_SPARE_A, SIG_NONE, HOW_BLOCK, '0,
                                         DISP_DEFAULT, 1'b0, 1'b0));
        request_q.push_back(make_request(MODE_SPARE_B, SIG_LAST, HOW_SET, '1,
                                         DISP_HANDLER, 1'b1, 1'b1));
        request_q.push_back(make_request(MODE_SPARE_C, SIG_FIRST, HOW_BAD, '1,
                                         DISP_BAD, 1'b1, 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // each batch under one of four idling patterns; drain fully in between
        for (int b = 0; b < NUM_BATCHES; b++) begin
            case (b % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
                default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
            endcase
            for (int n = 0; n < BATCH_ITEMS; n++)
                request_q.push_back(random_request());
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spmd_pkg.sv
rtl/spmd_in_stage.sv
rtl/spmd_core.sv
rtl/spmd_out_stage.sv
rtl/signal_pending_mask_dispatch.sv
bench/signal_pending_mask_dispatch_test.sv
